/* rtl/aso_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_pkg: shared types and codes for the shifter operand pipeline
// Shift type codes, carry select codes and the word that travels between
// the decode, rotate and merge stages.
// ----------------------------------------------------------------------------
package aso_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AmtW  = 5;

  // Shift type, instruction bits 6:5.
  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  // Where the carry-out comes from once the word is rotated.
  localparam logic [1:0] CSEL_FIX   = 2'd0;
  localparam logic [1:0] CSEL_ROT31 = 2'd1;
  localparam logic [1:0] CSEL_ROT0  = 2'd2;

  // Rotate amounts handled by the two rotate stages.
  localparam logic [AmtW-1:0] ROT_HI_MASK = 5'b11000;
  localparam logic [AmtW-1:0] ROT_LO_MASK = 5'b00111;

  // Every shift is a right rotation followed by a keep mask and a fill bit.
  typedef struct packed {
    logic [DataW-1:0] data;
    logic [AmtW-1:0]  rot;
    logic [DataW-1:0] keep;
    logic             fill;
    logic [1:0]       csel;
    logic             cfix;
  } stage_t;

endpackage

/* rtl/aso_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_decode: first pipeline stage
// Resolves the shift type, amount and all special cases into a rotate
// amount, a keep mask, a fill bit and a carry source, and registers them.
// ----------------------------------------------------------------------------
module aso_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [11:0]         in_operand_bits,
  input  logic [31:0]         in_rm_value,
  input  logic [31:0]         in_rs_value,
  input  logic                in_carry_in,
  output logic                out_valid,
  input  logic                out_ready,
  output aso_pkg::stage_t     out_data
);

  logic            valid_r;
  logic            valid_nxt;
  aso_pkg::stage_t data_r;
  aso_pkg::stage_t data_nxt;

  logic [1:0]  sh_type;
  logic        by_reg;
  logic [4:0]  imm_amt;
  logic [7:0]  reg_amt;
  logic [4:0]  amt;
  logic        sign;
  logic        normal;
  logic [31:0] ones;

  assign ones    = {32{1'b1}};
  assign sh_type = in_operand_bits[6:5];
  assign by_reg  = in_operand_bits[4];
  assign imm_amt = in_operand_bits[11:7];
  assign reg_amt = in_rs_value[7:0];
  assign amt     = by_reg ? reg_amt[4:0] : imm_amt;
  assign sign    = in_rm_value[31];

  // A plain shift by 1..31, or a register rotate by a nonzero low five bits.
  always_comb begin
    if (!by_reg) begin
      normal = (imm_amt != 5'd0);
    end else begin
      normal = (reg_amt != 8'd0) &&
               ((reg_amt < 8'd32) || ((sh_type == aso_pkg::SH_ROR) && (reg_amt[4:0] != 5'd0)));
    end
  end

  always_comb begin
    data_nxt.data = in_rm_value;
    data_nxt.rot  = 5'd0;
    data_nxt.keep = ones;
    data_nxt.fill = 1'b0;
    data_nxt.csel = aso_pkg::CSEL_FIX;
    data_nxt.cfix = in_carry_in;
    if (normal) begin
      unique case (sh_type)
        aso_pkg::SH_LSL: begin
          data_nxt.rot  = 5'd0 - amt;
          data_nxt.keep = ones << amt;
          data_nxt.csel = aso_pkg::CSEL_ROT0;
        end
        aso_pkg::SH_LSR: begin
          data_nxt.rot  = amt;
          data_nxt.keep = ones >> amt;
          data_nxt.csel = aso_pkg::CSEL_ROT31;
        end
        aso_pkg::SH_ASR: begin
          data_nxt.rot  = amt;
          data_nxt.keep = ones >> amt;
          data_nxt.fill = sign;
          data_nxt.csel = aso_pkg::CSEL_ROT31;
        end
        default: begin
          data_nxt.rot  = amt;
          data_nxt.csel = aso_pkg::CSEL_ROT31;
        end
      endcase
    end else if (!by_reg) begin
      // Immediate amount of zero: LSR and ASR by 32, ROR becomes RRX.
      unique case (sh_type)
        aso_pkg::SH_LSL: begin
        end
        aso_pkg::SH_LSR: begin
          data_nxt.keep = '0;
          data_nxt.cfix = sign;
        end
        aso_pkg::SH_ASR: begin
          data_nxt.keep = '0;
          data_nxt.fill = sign;
          data_nxt.cfix = sign;
        end
        default: begin
          data_nxt.rot  = 5'd1;
          data_nxt.keep = ones >> 1;
          data_nxt.fill = in_carry_in;
          data_nxt.csel = aso_pkg::CSEL_ROT31;
        end
      endcase
    end else if (reg_amt != 8'd0) begin
      // Register amount of 32 or more.
      unique case (sh_type)
        aso_pkg::SH_LSL: begin
          data_nxt.keep = '0;
          data_nxt.cfix = (reg_amt == 8'd32) ? in_rm_value[0] : 1'b0;
        end
        aso_pkg::SH_LSR: begin
          data_nxt.keep = '0;
          data_nxt.cfix = (reg_amt == 8'd32) ? sign : 1'b0;
        end
        aso_pkg::SH_ASR: begin
          data_nxt.keep = '0;
          data_nxt.fill = sign;
          data_nxt.cfix = sign;
        end
        default: begin
          data_nxt.cfix = sign;
        end
      endcase
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/aso_rotate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_rotate: partial rotate stage
// Rotates the word right by the bits of its rotate amount that the mask
// selects, and registers the result with the rest of the stage word.
// ----------------------------------------------------------------------------
module aso_rotate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [aso_pkg::AmtW-1:0]    amt_mask,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  aso_pkg::stage_t             in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output aso_pkg::stage_t             out_data
);

  logic            valid_r;
  logic            valid_nxt;
  aso_pkg::stage_t data_r;
  aso_pkg::stage_t data_nxt;

  logic [aso_pkg::AmtW-1:0]    amt;
  logic [2*aso_pkg::DataW-1:0] doubled;

  assign amt     = in_data.rot & amt_mask;
  assign doubled = {in_data.data, in_data.data} >> amt;

  always_comb begin
    data_nxt      = in_data;
    data_nxt.data = doubled[aso_pkg::DataW-1:0];
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* rtl/aso_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aso_merge: last pipeline stage
// Applies the keep mask and fill bit to the rotated word, picks the
// carry-out and holds the result word for the output channel.
// ----------------------------------------------------------------------------
module aso_merge (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  aso_pkg::stage_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_operand_value,
  output logic              out_shift_carry
);

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] value_r;
  logic [31:0] value_nxt;
  logic        carry_r;
  logic        carry_nxt;

  assign value_nxt = (in_data.data & in_data.keep) | (~in_data.keep & {32{in_data.fill}});

  // The carry is taken from the rotated word before masking.
  always_comb begin
    case (in_data.csel)
      aso_pkg::CSEL_ROT31: carry_nxt = in_data.data[31];
      aso_pkg::CSEL_ROT0:  carry_nxt = in_data.data[0];
      default:             carry_nxt = in_data.cfix;
    endcase
  end

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      value_r <= value_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_operand_value = value_r;
  assign out_shift_carry   = carry_r;

endmodule

/* rtl/arm_shifter_operand_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_shifter_operand_core: data-processing shifter operand
// Computes the shifted second operand and the shifter carry-out from
// instruction bits 11:0, Rm, Rs and the C flag, in a four-stage pipeline.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_ready  operand_bits, rm_value, rs_value, carry_in
//   out      out_valid/out_ready  operand_value, shift_carry
//
// A word passes four register stages: decode, rotate by the upper amount
// bits, rotate by the lower amount bits, then mask and carry select. Decode
// captures it at the accepting edge, and out_valid rises once the merge stage holds it.
// One word is accepted per cycle when the output is taken.
// Reset clears the stage valid bits only. Each stage holds its word while
// the next stage is full and stalled, so a stall fills the empty stages
// before in_ready drops.
// ----------------------------------------------------------------------------
module arm_shifter_operand_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_operand_bits,
  input  logic [31:0] in_rm_value,
  input  logic [31:0] in_rs_value,
  input  logic        in_carry_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_operand_value,
  output logic        out_shift_carry
);

  logic            dec_valid;
  logic            dec_ready;
  aso_pkg::stage_t dec_data;
  logic            hi_valid;
  logic            hi_ready;
  aso_pkg::stage_t hi_data;
  logic            lo_valid;
  logic            lo_ready;
  aso_pkg::stage_t lo_data;

  aso_decode u_decode (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operand_bits (in_operand_bits),
    .in_rm_value     (in_rm_value),
    .in_rs_value     (in_rs_value),
    .in_carry_in     (in_carry_in),
    .out_valid       (dec_valid),
    .out_ready       (dec_ready),
    .out_data        (dec_data)
  );

  aso_rotate u_rotate_hi (
    .clk       (clk),
    .rst_n     (rst_n),
    .amt_mask  (aso_pkg::ROT_HI_MASK),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (hi_valid),
    .out_ready (hi_ready),
    .out_data  (hi_data)
  );

  aso_rotate u_rotate_lo (
    .clk       (clk),
    .rst_n     (rst_n),
    .amt_mask  (aso_pkg::ROT_LO_MASK),
    .in_valid  (hi_valid),
    .in_ready  (hi_ready),
    .in_data   (hi_data),
    .out_valid (lo_valid),
    .out_ready (lo_ready),
    .out_data  (lo_data)
  );

  aso_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (lo_valid),
    .in_ready          (lo_ready),
    .in_data           (lo_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_operand_value (out_operand_value),
    .out_shift_carry   (out_shift_carry)
  );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for arm_shifter_operand_core
// Drives operand words through the valid/ready input channel and checks each
// result word against an in-bench shifter predictor, over directed corner
// cases and biased random words, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomPerPhase = 125;
  localparam int unsigned MaxPrinted = 100;

  typedef struct packed {
    logic [11:0] bits;
    logic [31:0] rm;
    logic [31:0] rs;
    logic        carry_flag;
  } operand_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic        carry;
  } shifter_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] in_operand_bits = '0;
  logic [31:0] in_rm_value = '0;
  logic [31:0] in_rs_value = '0;
  logic        in_carry_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_operand_value;
  logic        out_shift_carry;

  operand_word_t   pending_words[$];
  shifter_result_t expected_results[$];
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     mismatch_count = 0;
  int unsigned     idle_cycles = 0;

  arm_shifter_operand_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operand_bits   (in_operand_bits),
    .in_rm_value       (in_rm_value),
    .in_rs_value       (in_rs_value),
    .in_carry_in       (in_carry_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_operand_value (out_operand_value),
    .out_shift_carry   (out_shift_carry)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shift by an amount from 1 to 31, the same for both operand forms.
  function automatic shifter_result_t shift_in_range(logic [31:0] rm, logic [1:0] sh, int n);
    shifter_result_t r;
    logic [63:0]     twice;
    twice = {rm, rm} >> n;
    r.carry = rm[n-1];
    case (sh)
      aso_pkg::SH_LSL: begin
        r.value = rm << n;
        r.carry = rm[32-n];
      end
      aso_pkg::SH_LSR: r.value = rm >> n;
      aso_pkg::SH_ASR: r.value = 32'($signed(rm) >>> n);
      default: r.value = twice[31:0];
    endcase
    return r;
  endfunction

  function automatic shifter_result_t predict_shifter(operand_word_t w);
    shifter_result_t r;
    logic [1:0]      sh;
    logic            sign;
    int              amt;
    sh = w.bits[6:5];
    sign = w.rm[31];
    r.value = w.rm;
    r.carry = w.carry_flag;
    if (!w.bits[4]) begin
      amt = int'(w.bits[11:7]);
      if (amt != 0) begin
        r = shift_in_range(w.rm, sh, amt);
      end else begin
        // A zero immediate means a shift by 32 for LSR and ASR, and RRX for ROR.
        case (sh)
          aso_pkg::SH_LSL: r.carry = w.carry_flag;
          aso_pkg::SH_LSR: begin
            r.value = '0;
            r.carry = sign;
          end
          aso_pkg::SH_ASR: begin
            r.value = {32{sign}};
            r.carry = sign;
          end
          default: begin
            r.value = {w.carry_flag, w.rm[31:1]};
            r.carry = w.rm[0];
          end
        endcase
      end
    end else begin
      amt = int'(w.rs[7:0]);
      if (amt != 0 && amt < 32) begin
        r = shift_in_range(w.rm, sh, amt);
      end else if (amt >= 32) begin
        case (sh)
          aso_pkg::SH_LSL: begin
            r.value = '0;
            r.carry = (amt == 32) ? w.rm[0] : 1'b0;
          end
          aso_pkg::SH_LSR: begin
            r.value = '0;
            r.carry = (amt == 32) ? sign : 1'b0;
          end
          aso_pkg::SH_ASR: begin
            r.value = {32{sign}};
            r.carry = sign;
          end
          default: begin
            if (amt % 32 == 0) begin
              r.carry = sign;
            end else begin
              r = shift_in_range(w.rm, sh, amt % 32);
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic operand_word_t make_word(logic reg_form, logic [1:0] sh, logic [4:0] hi,
                                              logic [31:0] rm, logic [31:0] rs, logic c);
    operand_word_t w;
    w.bits = {hi, sh, reg_form, 4'($urandom)};
    w.rm = rm;
    w.rs = rs;
    w.carry_flag = c;
    return w;
  endfunction

  // Register amounts are steered toward zero, 32, multiples of 32 and the
  // ranges on either side, which is where the special cases live.
  function automatic operand_word_t random_operand_word();
    operand_word_t w;
    w.bits = 12'($urandom);
    w.rs = $urandom;
    w.carry_flag = 1'($urandom);
    case ($urandom_range(7))
      0: w.rm = '0;
      1: w.rm = '1;
      2: w.rm = 32'h8000_0000;
      3: w.rm = 32'h0000_0001;
      default: w.rm = $urandom;
    endcase
    if (!w.bits[4] && $urandom_range(3) == 0) w.bits[11:7] = '0;
    case ($urandom_range(5))
      0: w.rs[7:0] = 8'd0;
      1: w.rs[7:0] = 8'($urandom_range(1, 31));
      2: w.rs[7:0] = 8'd32;
      3: w.rs[7:0] = {3'($urandom_range(1, 7)), 5'd0};
      4: w.rs[7:0] = 8'($urandom_range(33, 255));
      default: w.rs[7:0] = 8'($urandom);
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    end
  endtask

  always @(posedge clk) begin : word_driver
    operand_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_operand_bits <= w.bits;
        in_rm_value <= w.rm;
        in_rs_value <= w.rs;
        in_carry_in <= w.carry_flag;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    operand_word_t   w;
    shifter_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (in_valid && in_ready) begin
        w = '{in_operand_bits, in_rm_value, in_rs_value, in_carry_in};
        expected_results.push_back(predict_shifter(w));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", out_operand_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_operand_value !== want.value) begin
            report_mismatch("operand_value", out_operand_value, want.value);
          end
          if (out_shift_carry !== want.carry) begin
            report_mismatch("shift_carry", 32'(out_shift_carry), 32'(want.carry));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("arm_shifter_operand_core regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    operand_word_t w;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners, sent back to back with no idling.
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_LSL, 5'd0, 32'h8000_0001,
                                      $urandom, 1'b1));
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_LSR, 5'd0, 32'h8000_0001,
                                      $urandom, 1'b0));
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_ASR, 5'd0, 32'h8000_0001,
                                      $urandom, 1'b0));
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_ASR, 5'd0, 32'h7FFF_FFFE,
                                      $urandom, 1'b1));
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_ROR, 5'd0, 32'h8000_0001,
                                      $urandom, 1'b1));
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_ROR, 5'd0, 32'h0000_0002,
                                      $urandom, 1'b0));
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_LSL, 5'd1, 32'hFFFF_FFFF,
                                      $urandom, 1'b0));
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_LSL, 5'd31, 32'h0000_0003,
                                      $urandom, 1'b0));
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_LSR, 5'd31, 32'h8000_0000,
                                      $urandom, 1'b0));
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_ASR, 5'd31, 32'h8000_0000,
                                      $urandom, 1'b1));
    pending_words.push_back(make_word(1'b0, aso_pkg::SH_ROR, 5'd1, 32'h0000_0001,
                                      $urandom, 1'b0));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_ROR, {4'($urandom), 1'b0},
                                      32'h1234_5678, 32'hFFFF_FF00, 1'b1));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_LSL, {4'($urandom), 1'b0},
                                      32'h0000_0001, 32'd32, 1'b0));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_LSL, {4'($urandom), 1'b0},
                                      32'hFFFF_FFFF, 32'd33, 1'b1));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_LSR, {4'($urandom), 1'b0},
                                      32'h8000_0000, 32'd32, 1'b0));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_LSR, {4'($urandom), 1'b0},
                                      32'hFFFF_FFFF, 32'd255, 1'b1));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_ASR, {4'($urandom), 1'b0},
                                      32'h8000_0000, 32'd32, 1'b0));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_ASR, {4'($urandom), 1'b0},
                                      32'h7FFF_FFFF, 32'd200, 1'b1));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_ROR, {4'($urandom), 1'b0},
                                      32'h8000_0001, 32'd32, 1'b0));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_ROR, {4'($urandom), 1'b0},
                                      32'h1234_5678, 32'h1234_5640, 1'b0));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_ROR, {4'($urandom), 1'b0},
                                      32'h0000_0001, 32'd33, 1'b0));
    // Bit 7 set in a register form must not change the shift.
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_LSR, {4'($urandom), 1'b1},
                                      32'hF000_000F, 32'd4, 1'b1));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_LSL, {4'($urandom), 1'b0},
                                      32'h0000_0001, 32'd31, 1'b0));
    pending_words.push_back(make_word(1'b1, aso_pkg::SH_ASR, {4'($urandom), 1'b0},
                                      32'h8000_0001, 32'd1, 1'b0));
    w = '{12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1};
    pending_words.push_back(w);
    w = '{12'h000, 32'h0000_0000, 32'h0000_0000, 1'b0};
    pending_words.push_back(w);

    // Each phase starts only once the previous one has fully drained, so the
    // sender sits idle with nothing in flight at every boundary.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 63;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 63;
        end
        default: begin
          send_idle_pct = 25;
          recv_stall_pct = 25;
        end
      endcase
      for (int i = 0; i < RandomPerPhase; i++) begin
        pending_words.push_back(random_operand_word());
      end
      while (pending_words.size() != 0 || in_valid || expected_results.size() != 0) begin
        @(negedge clk);
      end
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("arm_shifter_operand_core regression: pass");
    end else begin
      $display("arm_shifter_operand_core regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/aso_pkg.sv
rtl/aso_decode.sv
rtl/aso_rotate.sv
rtl/aso_merge.sv
rtl/arm_shifter_operand_core.sv
sim/tb_top.sv
